// ===== sv/ray_sphere_intersection_top_macros.svh =====
// Assertion helpers for the ray/sphere block. Both expect clk and rst in scope.
`ifndef RAY_SPHERE_INTERSECTION_TOP_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, idle while rst is high.
`define RSI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle while rst is high.
`define RSI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

  localparam int DIR_WIDTH    = 14;
  localparam int RADIUS_WIDTH = 23;
  localparam int FRAC_BITS    = 12;
  localparam int DIST_WIDTH   = 28;

  // Width of q = h*h + r*r - |v|^2 for a given coordinate width.
  // |h| < 2^(w+3), so h*h < 2^(2w+6); r*r < 2^(2*RADIUS_WIDTH).
  function automatic int q_width(input int w);
    int hsq;
    int rsq;
    hsq = 2 * w + 6;
    rsq = 2 * RADIUS_WIDTH;
    return ((hsq > rsq) ? hsq : rsq) + 1;
  endfunction

  // Width of floor(sqrt(q)).
  function automatic int root_width(input int w);
    return (q_width(w) + 1) >> 1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rsi_ray_if.sv =====
`default_nettype none

interface rsi_ray_if #(
  parameter int COORD_WIDTH = 24
) ();
  import rsi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [DIR_WIDTH-1:0]   dir_x;
  logic signed [DIR_WIDTH-1:0]   dir_y;
  logic signed [DIR_WIDTH-1:0]   dir_z;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic [RADIUS_WIDTH-1:0]       sphere_radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/rsi_hit_if.sv =====
`default_nettype none

interface rsi_hit_if ();
  import rsi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [DIST_WIDTH-1:0] distance;

  modport source (
    output valid, hit, distance,
    input  ready
  );

  modport sink (
    input  valid, hit, distance,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/ray_sphere_intersection_top.sv =====
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  ray      | in  | valid / ready | origin_x/y/z, dir_x/y/z, center_x/y/z,
//           |     |               | sphere_radius
//  result   | out | valid / ready | hit, distance
//
//  One transaction per cycle in each direction when result.ready stays high.
//  The pipeline runs through the discriminant stages, then R = (q_width(COORD_WIDTH) + 1) / 2
//  root stages of the square root (one root bit per stage), then the output register.
//  rst is synchronous and clears only the valid bits of every stage.
//  A stalled result freezes the whole pipeline in place; bubbles drain while
//  the output register is empty, so nothing is lost or repeated.
`default_nettype none
`include "ray_sphere_intersection_top_macros.svh"

module ray_sphere_intersection_top #(
  parameter int COORD_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  rsi_ray_if.sink     ray,
  rsi_hit_if.source   result
);
  import rsi_pkg::*;

  localparam int QW = q_width(COORD_WIDTH);
  localparam int SW = root_width(COORD_WIDTH);
  localparam int HW = COORD_WIDTH + 4;

  logic                          en;
  logic                          out_valid;

  logic signed [COORD_WIDTH-1:0] origin [3];
  logic signed [DIR_WIDTH-1:0]   dir [3];
  logic signed [COORD_WIDTH-1:0] center [3];

  logic                          dq_valid;
  logic                          dq_hit;
  logic [QW-1:0]                 dq_q;
  logic signed [HW-1:0]          dq_h;

  logic                          sq_valid;
  logic                          sq_hit;
  logic [SW-1:0]                 sq_root;
  logic signed [HW-1:0]          sq_h;

  // Advance every stage whenever the output register is free or being drained.
  assign en        = !out_valid || result.ready;
  assign ray.ready = en;

  // Gather the vector components for the per-axis math.
  assign origin[0] = ray.origin_x;
  assign origin[1] = ray.origin_y;
  assign origin[2] = ray.origin_z;
  assign dir[0]    = ray.dir_x;
  assign dir[1]    = ray.dir_y;
  assign dir[2]    = ray.dir_z;
  assign center[0] = ray.center_x;
  assign center[1] = ray.center_y;
  assign center[2] = ray.center_z;

  // Discriminant: v = o - c, h = floor(dot(v, d) / 4096), q = h*h + r*r - |v|^2.
  rsi_disc #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray.valid),
    .origin    (origin),
    .dir       (dir),
    .center    (center),
    .radius    (ray.sphere_radius),
    .out_valid (dq_valid),
    .out_hit   (dq_hit),
    .q         (dq_q),
    .h         (dq_h)
  );

  // s = floor(sqrt(q)); q arrives as zero on a miss.
  rsi_sqrt #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dq_valid),
    .in_hit    (dq_hit),
    .in_q      (dq_q),
    .in_h      (dq_h),
    .out_valid (sq_valid),
    .out_hit   (sq_hit),
    .root      (sq_root),
    .out_h     (sq_h)
  );

  // Pick -h - s or -h + s, clamp to the distance range, zero on a miss.
  rsi_root #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_hit    (sq_hit),
    .root      (sq_root),
    .in_h      (sq_h),
    .out_valid (out_valid),
    .hit       (result.hit),
    .distance  (result.distance)
  );

  assign result.valid = out_valid;

  // A miss always leaves with a zero distance.
  `RSI_ASSERT_NOW(a_miss_zero, result.valid && !result.hit, result.distance == '0, "miss not zero")

  // A miss reaches the root stage with a zero root.
  `RSI_ASSERT_NOW(a_miss_root, sq_valid && !sq_hit, sq_root == '0, "miss with nonzero root")

  // Every advance moves the last root stage into the output register.
  `RSI_ASSERT_NEXT(a_advance, en, out_valid == $past(sq_valid), "valid out of step")

endmodule

`default_nettype wire

// ===== sv/rsi_disc.sv =====
`default_nettype none

// Six-stage front end: offset, products, sums, |h| split squares, p, q.
module rsi_disc #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic signed [COORD_WIDTH-1:0]               origin [3],
  input  logic signed [rsi_pkg::DIR_WIDTH-1:0]        dir [3],
  input  logic signed [COORD_WIDTH-1:0]               center [3],
  input  logic [rsi_pkg::RADIUS_WIDTH-1:0]            radius,
  output logic                                        out_valid,
  output logic                                        out_hit,
  output logic [rsi_pkg::q_width(COORD_WIDTH)-1:0]    q,
  output logic signed [COORD_WIDTH+3:0]               h
);
  import rsi_pkg::*;

  localparam int VW  = COORD_WIDTH + 1;
  localparam int PW  = COORD_WIDTH + 15;
  localparam int DW  = COORD_WIDTH + 17;
  localparam int HW  = COORD_WIDTH + 4;
  localparam int HM  = COORD_WIDTH + 3;
  localparam int HL  = HM / 2;
  localparam int HH  = HM - HL;
  localparam int SQW = 2 * COORD_WIDTH;
  localparam int VVW = 2 * COORD_WIDTH + 2;
  localparam int RSW = 2 * RADIUS_WIDTH;
  localparam int QW  = q_width(COORD_WIDTH);

  logic [5:0] vld;

  // stage 1
  logic signed [VW-1:0]        v1 [3];
  logic signed [DIR_WIDTH-1:0] d1 [3];
  logic [RADIUS_WIDTH-1:0]     r1;
  // stage 2
  logic signed [PW-1:0]        pd2 [3];
  logic [SQW-1:0]              sq2 [3];
  logic [RSW-1:0]              rsq2;
  // stage 3
  logic signed [HW-1:0]        h3;
  logic [VVW-1:0]              vv3;
  logic [RSW-1:0]              rsq3;
  // stage 4
  logic [2*HH-1:0]             pa4;
  logic [HH+HL-1:0]            pb4;
  logic [2*HL-1:0]             pc4;
  logic signed [HW-1:0]        h4;
  logic [VVW-1:0]              vv4;
  logic [RSW-1:0]              rsq4;
  // stage 5
  logic [QW-1:0]               p5;
  logic signed [HW-1:0]        h5;
  logic [VVW-1:0]              vv5;

  logic signed [VW-1:0]        v_next [3];
  logic [COORD_WIDTH-1:0]      vm [3];
  logic signed [DW-1:0]        dot;
  logic signed [HW-1:0]        h_next;
  logic [VVW-1:0]              vv_next;
  logic [HM-1:0]               hm;
  logic [QW-1:0]               p_next;
  logic [QW:0]                 diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_next[i] = VW'(origin[i]) - VW'(center[i]);
      vm[i]     = v1[i][VW-1] ? COORD_WIDTH'(-v1[i]) : COORD_WIDTH'(v1[i]);
    end
    dot     = DW'(pd2[0]) + DW'(pd2[1]) + DW'(pd2[2]);
    // arithmetic shift floors toward minus infinity
    h_next  = HW'(dot >>> FRAC_BITS);
    vv_next = VVW'(sq2[0]) + VVW'(sq2[1]) + VVW'(sq2[2]);
    hm      = h3[HW-1] ? HM'(-h3) : HM'(h3);
    p_next  = (QW'(pa4) << (2 * HL)) + (QW'(pb4) << (HL + 1)) + QW'(pc4) + QW'(rsq4);
    diff    = (QW + 1)'(p5) - (QW + 1)'(vv5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1[i]  <= v_next[i];
        d1[i]  <= dir[i];
        pd2[i] <= PW'(v1[i]) * PW'(d1[i]);
        sq2[i] <= SQW'(vm[i]) * SQW'(vm[i]);
      end
      r1   <= radius;
      rsq2 <= RSW'(r1) * RSW'(r1);

      h3   <= h_next;
      vv3  <= vv_next;
      rsq3 <= rsq2;

      pa4  <= (2 * HH)'(hm[HM-1:HL]) * (2 * HH)'(hm[HM-1:HL]);
      pb4  <= (HH + HL)'(hm[HM-1:HL]) * (HH + HL)'(hm[HL-1:0]);
      pc4  <= (2 * HL)'(hm[HL-1:0]) * (2 * HL)'(hm[HL-1:0]);
      h4   <= h3;
      vv4  <= vv3;
      rsq4 <= rsq3;

      p5   <= p_next;
      h5   <= h4;
      vv5  <= vv4;

      // borrow out of the subtract marks a miss; feed zero to the root on a miss
      out_hit <= ~diff[QW];
      q       <= diff[QW] ? '0 : diff[QW-1:0];
      h       <= h5;
    end
  end

  assign out_valid = vld[5];

endmodule

`default_nettype wire

// ===== sv/rsi_sqrt.sv =====
`default_nettype none

// Pipelined digit-by-digit square root: one root bit per stage.
module rsi_sqrt #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic                                         in_hit,
  input  logic [rsi_pkg::q_width(COORD_WIDTH)-1:0]     in_q,
  input  logic signed [COORD_WIDTH+3:0]                in_h,
  output logic                                         out_valid,
  output logic                                         out_hit,
  output logic [rsi_pkg::root_width(COORD_WIDTH)-1:0]  root,
  output logic signed [COORD_WIDTH+3:0]                out_h
);
  import rsi_pkg::*;

  localparam int SW = root_width(COORD_WIDTH);
  localparam int QP = 2 * SW;
  localparam int RW = SW + 2;
  localparam int HW = COORD_WIDTH + 4;

  logic [SW-1:0]        vld;
  logic [SW-1:0]        hitp;
  logic signed [HW-1:0] hp [SW];
  logic [RW-1:0]        rem [SW];
  logic [SW-1:0]        rt [SW];
  logic [QP-1:0]        qs [SW];

  logic [RW-1:0]        rem_in [SW];
  logic [SW-1:0]        rt_in [SW];
  logic [QP-1:0]        qs_in [SW];
  logic [RW-1:0]        rr [SW];
  logic [RW-1:0]        trial [SW];
  logic [SW-1:0]        take;

  always_comb begin
    rem_in[0] = '0;
    rt_in[0]  = '0;
    qs_in[0]  = QP'(in_q);
    for (int k = 1; k < SW; k++) begin
      rem_in[k] = rem[k-1];
      rt_in[k]  = rt[k-1];
      qs_in[k]  = qs[k-1];
    end
    for (int k = 0; k < SW; k++) begin
      // bring down the next two radicand bits, try root*4 + 1
      rr[k]    = {rem_in[k][RW-3:0], qs_in[k][QP-1 -: 2]};
      trial[k] = {rt_in[k], 2'b01};
      take[k]  = (rr[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hitp  <= {hitp[SW-2:0], in_hit};
      hp[0] <= in_h;
      for (int k = 1; k < SW; k++) begin
        hp[k] <= hp[k-1];
      end
      for (int k = 0; k < SW; k++) begin
        rem[k] <= take[k] ? (rr[k] - trial[k]) : rr[k];
        rt[k]  <= {rt_in[k][SW-2:0], take[k]};
        qs[k]  <= {qs_in[k][QP-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[SW-1];
  assign out_hit   = hitp[SW-1];
  assign root      = rt[SW-1];
  assign out_h     = hp[SW-1];

endmodule

`default_nettype wire

// ===== sv/rsi_root.sv =====
`default_nettype none

// Root pick, saturation and output register.
module rsi_root #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic                                         in_hit,
  input  logic [rsi_pkg::root_width(COORD_WIDTH)-1:0]  root,
  input  logic signed [COORD_WIDTH+3:0]                in_h,
  output logic                                         out_valid,
  output logic                                         hit,
  output logic signed [rsi_pkg::DIST_WIDTH-1:0]        distance
);
  import rsi_pkg::*;

  localparam int HW = COORD_WIDTH + 4;
  localparam int SW = root_width(COORD_WIDTH);
  localparam int TW = ((HW > SW) ? HW : SW) + 2;
  localparam int ST = ((TW > DIST_WIDTH) ? TW : DIST_WIDTH) + 1;
  localparam logic signed [ST-1:0] DMAX = ST'((2 ** (DIST_WIDTH - 1)) - 1);
  localparam logic signed [ST-1:0] DMIN = ST'(-(2 ** (DIST_WIDTH - 1)));

  logic signed [TW-1:0] neg_h;
  logic signed [TW-1:0] t0;
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] pick;
  logic signed [ST-1:0] wide;
  logic signed [ST-1:0] sat;

  always_comb begin
    neg_h = -TW'(in_h);
    t0    = neg_h - TW'(root);
    t1    = neg_h + TW'(root);
    // near root only when it lies ahead and the roots differ
    pick  = (!t0[TW-1] && (t0 != '0) && (t0 < t1)) ? t0 : t1;
    wide  = ST'(pick);
    if (wide > DMAX) begin
      sat = DMAX;
    end else if (wide < DMIN) begin
      sat = DMIN;
    end else begin
      sat = wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= in_hit;
      distance <= in_hit ? sat[DIST_WIDTH-1:0] : '0;
    end
  end

endmodule

`default_nettype wire
